[hdl/bdh_pkg.sv]
// Shared types and constants for the button debounce and hold detector.
package bdh_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  // Configuration register indexes.
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_HOLD     = 1'b1;

  // Input kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_INIT   = 1'b1;

  // Event codes.
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_HOLD    = 2'd2;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] event_res;
    logic       button_state;
  } result_t;

endpackage

[hdl/bdh_cfg_regs.sv]
// Configuration register bank for the debounce and hold times.
module bdh_cfg_regs import bdh_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= CfgW'(50);
      cfg_q.hold_ms     <= CfgW'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata_i;
        CFG_HOLD:     cfg_q.hold_ms     <= cfg_wdata_i;
        default:      cfg_q             <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/bdh_core.sv]
// Debounce and hold state with the per-transaction decision logic.
module bdh_core import bdh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             kind_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  logic             stable_q, stable_d;
  logic             running_q, running_d;
  logic [TimeW-1:0] dbn_start_q, dbn_start_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic             hold_rep_q, hold_rep_d;

  logic [TimeW-1:0] dbn_elapsed;
  logic [TimeW-1:0] hold_elapsed;
  logic             dbn_done;
  logic             hold_due;

  assign dbn_elapsed  = now_ms_i - dbn_start_q;
  assign hold_elapsed = now_ms_i - press_start_q;
  assign dbn_done     = dbn_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms};
  assign hold_due     = hold_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.hold_ms};

  always_comb begin
    stable_d      = stable_q;
    running_d     = running_q;
    dbn_start_d   = dbn_start_q;
    press_start_d = press_start_q;
    hold_rep_d    = hold_rep_q;
    res_o         = '0;
    if (fire_i) begin
      if (kind_i == KIND_INIT) begin
        stable_d      = level_i;
        running_d     = 1'b0;
        dbn_start_d   = '0;
        press_start_d = now_ms_i;
        hold_rep_d    = level_i;
      end else if (level_i != stable_q && running_q && dbn_done) begin
        // The changed level has persisted long enough: take it.
        stable_d           = level_i;
        running_d          = 1'b0;
        dbn_start_d        = '0;
        hold_rep_d         = 1'b0;
        res_o.valid        = 1'b1;
        res_o.button_state = level_i;
        if (level_i) begin
          press_start_d   = now_ms_i;
          res_o.event_res = EV_PRESS;
        end else begin
          res_o.event_res = EV_RELEASE;
        end
      end else begin
        if (level_i == stable_q) begin
          running_d = 1'b0;
        end else if (!running_q) begin
          running_d   = 1'b1;
          dbn_start_d = now_ms_i;
        end
        if (stable_q && !hold_rep_q && hold_due) begin
          hold_rep_d         = 1'b1;
          res_o.valid        = 1'b1;
          res_o.event_res    = EV_HOLD;
          res_o.button_state = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q      <= 1'b0;
      running_q     <= 1'b0;
      dbn_start_q   <= '0;
      press_start_q <= '0;
      hold_rep_q    <= 1'b0;
    end else begin
      stable_q      <= stable_d;
      running_q     <= running_d;
      dbn_start_q   <= dbn_start_d;
      press_start_q <= press_start_d;
      hold_rep_q    <= hold_rep_d;
    end
  end

  a_press_sets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == EV_PRESS |-> res_o.button_state)
    else $error("press event without pressed state");

  a_init_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && kind_i == KIND_INIT |-> !res_o.valid)
    else $error("init transaction produced a result");

  a_hold_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == EV_HOLD |-> stable_q && !hold_rep_q)
    else $error("hold event while released or already reported");

  a_hold_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == EV_HOLD |=> hold_rep_q)
    else $error("hold event not recorded");

endmodule

[hdl/button_debounce_hold_detector_unit.sv]
// Top level of the button debounce and hold detector.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: level, now_ms; tuser: kind
//  m_axis    out        tdata: event_res, button_state
//  cfg       in         write enable, index, 16-bit data
//
//  One transaction per cycle unless the output stalls; an input register
//  feeds the decision logic, whose outcome lands in an output register.
//  The 32-bit time subtract and compare set the path between the registers.
//  Reset clears the button state, the timers and both valid flags.
//  A stalled output holds the input register; new input is taken when the
//  input register is empty or drains in the same cycle.
module button_debounce_hold_detector_unit import bdh_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,   // [0] level, [32:1] now_ms, rest zero
  input  logic            s_axis_tuser,   // [0] kind
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [1:0] event_res, [2] button_state, rest zero
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  logic             in_valid_q;
  logic             kind_q;
  logic             level_q;
  logic [TimeW-1:0] now_q;
  logic             out_valid_q;
  logic [1:0]       event_q;
  logic             state_q;
  logic             consume;
  logic             out_free;
  cfg_t             cfg;
  result_t          res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign consume       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q  <= s_axis_tuser;
      level_q <= s_axis_tdata[0];
      now_q   <= s_axis_tdata[TimeW:1];
    end
  end

  bdh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdh_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (consume),
    .kind_i   (kind_q),
    .level_i  (level_q),
    .now_ms_i (now_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // The output register reloads whenever it is free, so an item without a
  // result clears the valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      event_q <= res.event_res;
      state_q <= res.button_state;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, state_q, event_q};

endmodule
